[rtl/core/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants of the coordinate text parser: parse phases,
// status codes, register indexes, character codes and the power-of-ten table.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int COORD_W  = 28;               // signed coordinate width
    localparam int MAG_W    = 27;               // unsigned magnitude width
    localparam int unsigned MAG_CAP = 99999999; // saturation point
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int POW_TABLE_W = 24;            // holds 10**7
    localparam int FRACTION_DIGITS_DEFAULT = 5;

    typedef enum logic [2:0] {
        PH_SKIP_LAT,
        PH_IN_LAT,
        PH_SKIP_LON,
        PH_IN_LON,
        PH_DONE
    } ctp_phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2
    } ctp_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAT_MIN = 2'd0,
        CFG_LAT_MAX = 2'd1,
        CFG_LON_MIN = 2'd2,
        CFG_LON_MAX = 2'd3
    } ctp_cfg_idx_t;

    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic signed [COORD_W-1:0] LAT_MIN_RST = -28'sd9000000;
    localparam logic signed [COORD_W-1:0] LAT_MAX_RST =  28'sd9000000;
    localparam logic signed [COORD_W-1:0] LON_MIN_RST = -28'sd18000000;
    localparam logic signed [COORD_W-1:0] LON_MAX_RST =  28'sd18000000;

    // Scale factor for missing fraction digits.
    function automatic logic [POW_TABLE_W-1:0] pow10(input logic [3:0] k);
        logic [POW_TABLE_W-1:0] r;
        case (k)
            4'd0:    r = 24'd1;
            4'd1:    r = 24'd10;
            4'd2:    r = 24'd100;
            4'd3:    r = 24'd1000;
            4'd4:    r = 24'd10000;
            4'd5:    r = 24'd100000;
            4'd6:    r = 24'd1000000;
            4'd7:    r = 24'd10000000;
            default: r = 24'd1;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/coordinate_text_parser_core.sv]
// ----------------------------------------------------------------------------
// coordinate_text_parser_core
// Parses a stream of ASCII characters into a latitude/longitude pair in
// fixed-point units of 10**-FRACTION_DIGITS degree, with range checking.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Beat carries
//  --------+-----------------------------------------+-------------------------
//  input   | s_valid s_ready s_char_code             | one character,
//          | s_end_of_text                           | end mark on the last one
//  result  | m_valid m_ready m_latitude m_longitude  | one coordinate pair per
//          | m_status                                | text (0 ok/1 bad/2 range)
//  config  | cfg_wr_en cfg_index cfg_wdata           | one limit register write
//
//  One character is taken every cycle while no end-marked beat waits. The
//  pipeline is input register, parse step, scale multiply, round/limit check
//  and output register; the result is taken from the output register.
//  Characters without the end mark are consumed even while the result side
//  stalls; an end-marked beat waits only when the finishing stages are full.
//  Synchronous active-low reset returns the limits to their defaults and
//  the parser to the start of a text.
// ----------------------------------------------------------------------------
module coordinate_text_parser_core #(
    parameter int FRACTION_DIGITS = ctp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input characters
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ctp_pkg::CHAR_W-1:0]           s_char_code,
    input  logic                                 s_end_of_text,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ctp_pkg::COORD_W-1:0]   m_latitude,
    output logic signed [ctp_pkg::COORD_W-1:0]   m_longitude,
    output logic [ctp_pkg::STATUS_W-1:0]         m_status,
    // limit registers
    input  logic                                 cfg_wr_en,
    input  logic [ctp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ctp_pkg::COORD_W-1:0]          cfg_wdata
);
    import ctp_pkg::*;

    localparam int FCNT_W = $clog2(FRACTION_DIGITS + 2);
    localparam int POW_W  = $clog2(10 ** FRACTION_DIGITS + 1);
    localparam int PROD_W = MAG_W + POW_W;
    localparam logic [FCNT_W-1:0] FD = FCNT_W'(FRACTION_DIGITS);
    localparam logic [MAG_W-1:0]  CAP = MAG_W'(MAG_CAP);

    // Token accumulator.
    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [FCNT_W-1:0] fcnt;
        logic              point;
        logic              rnd;
        logic              bad;
        logic              ovf;
    } tok_t;

    // One coordinate as captured at the end of a text.
    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [FCNT_W-1:0] fcnt;
        logic              rnd;
        logic              bad;
        logic              ovf;
        logic              missing;
    } lane_raw_t;

    // One coordinate after scaling.
    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] prod;
        logic              rnd;
        logic              bad;
        logic              ovf;
        logic              missing;
    } lane_prod_t;

    // Fold one character into a token.
    function automatic tok_t feed_char(input tok_t t, input logic [CHAR_W-1:0] c);
        tok_t              r;
        logic [MAG_W+3:0]  prod10;
        logic [3:0]        d;
        r = t;
        d = c[3:0];
        prod10 = ({4'b0, t.mag} << 3) + ({4'b0, t.mag} << 1) + {{MAG_W{1'b0}}, d};
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            if (!t.point || t.fcnt < FD) begin
                if (prod10 > {4'b0, CAP}) begin
                    r.mag = CAP;
                    r.ovf = 1'b1;
                end else begin
                    r.mag = prod10[MAG_W-1:0];
                end
                if (t.point) begin
                    r.fcnt = t.fcnt + 1'b1;
                end
            end else if (t.fcnt == FD) begin
                r.rnd  = (d >= 4'd5);
                r.fcnt = t.fcnt + 1'b1;
            end
        end else if (c == CH_POINT) begin
            r.point = 1'b1;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic lane_raw_t to_lane(input tok_t t, input logic missing);
        lane_raw_t r;
        r.neg     = t.neg;
        r.mag     = t.mag;
        r.fcnt    = t.fcnt;
        r.rnd     = t.rnd;
        r.bad     = t.bad;
        r.ovf     = t.ovf;
        r.missing = missing;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Limit registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] lat_min_reg, lat_max_reg, lon_min_reg, lon_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_min_reg <= LAT_MIN_RST;
            lat_max_reg <= LAT_MAX_RST;
            lon_min_reg <= LON_MIN_RST;
            lon_max_reg <= LON_MAX_RST;
        end else if (cfg_wr_en) begin
            case (ctp_cfg_idx_t'(cfg_index))
                CFG_LAT_MIN: lat_min_reg <= cfg_wdata;
                CFG_LAT_MAX: lat_max_reg <= cfg_wdata;
                CFG_LON_MIN: lon_min_reg <= cfg_wdata;
                CFG_LON_MAX: lon_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the one after it has room.
    // ------------------------------------------------------------------
    logic in_valid_reg, in_eot_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic f1_valid_reg, f2_valid_reg, m_valid_reg;
    logic out_free, f2_ready, f1_ready, parse_go;

    assign out_free = !m_valid_reg || m_ready;
    assign f2_ready = !f2_valid_reg || out_free;
    assign f1_ready = !f1_valid_reg || f2_ready;
    // Plain characters never wait; an end-marked beat needs room downstream.
    assign parse_go = in_valid_reg && (!in_eot_reg || f1_ready);
    assign s_ready  = !in_valid_reg || parse_go;

    // Input register: hold the beat until the parse step takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // ------------------------------------------------------------------
    // Parse step
    // ------------------------------------------------------------------
    ctp_phase_t phase_reg, phase_next, phase_step;
    tok_t       tok_reg, tok_step;
    tok_t       hl_reg, hl_step;      // raw latitude token, finished at the end
    logic       delim;

    assign delim = in_char_reg inside {CH_COLON, CH_COMMA, CH_SPACE};

    // Next phase: advance on token boundaries, restart after the end mark.
    always_comb begin
        phase_step = phase_reg;
        case (phase_reg)
            PH_SKIP_LAT: if (!delim) phase_step = PH_IN_LAT;
            PH_IN_LAT:   if (delim)  phase_step = PH_SKIP_LON;
            PH_SKIP_LON: if (!delim) phase_step = PH_IN_LON;
            PH_IN_LON:   if (delim)  phase_step = PH_DONE;
            default: ;
        endcase
        if (!parse_go) begin
            phase_next = phase_reg;
        end else if (in_eot_reg) begin
            phase_next = PH_SKIP_LAT;
        end else begin
            phase_next = phase_step;
        end
    end

    // Token datapath: open, extend or park the current token.
    always_comb begin
        tok_step = tok_reg;
        hl_step  = hl_reg;
        case (phase_reg)
            PH_SKIP_LAT, PH_SKIP_LON: begin
                if (!delim) begin
                    if (in_char_reg == CH_MINUS) begin
                        tok_step     = '0;
                        tok_step.neg = 1'b1;
                    end else begin
                        tok_step = feed_char('0, in_char_reg);
                    end
                end
            end
            PH_IN_LAT: begin
                if (delim) begin
                    hl_step = tok_reg;
                end else begin
                    tok_step = feed_char(tok_reg, in_char_reg);
                end
            end
            PH_IN_LON: begin
                if (!delim) begin
                    tok_step = feed_char(tok_reg, in_char_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP_LAT;
            tok_reg   <= '0;
            hl_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            if (parse_go) begin
                tok_reg <= tok_step;
                hl_reg  <= hl_step;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture both coordinates of a finished text.
    // ------------------------------------------------------------------
    lane_raw_t lat_raw_next, lon_raw_next, lat_raw_reg, lon_raw_reg;

    always_comb begin
        if (phase_step == PH_IN_LAT) begin
            lat_raw_next = to_lane(tok_step, 1'b0);
        end else begin
            lat_raw_next = to_lane(hl_step, phase_step == PH_SKIP_LAT);
        end
        lon_raw_next = to_lane(tok_step,
                               !(phase_step == PH_IN_LON || phase_step == PH_DONE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (f1_ready) begin
            f1_valid_reg <= parse_go && in_eot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_ready && parse_go && in_eot_reg) begin
            lat_raw_reg <= lat_raw_next;
            lon_raw_reg <= lon_raw_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by the missing fraction digits (one multiply per lane).
    // ------------------------------------------------------------------
    function automatic lane_prod_t scale_lane(input lane_raw_t r);
        lane_prod_t        p;
        logic [FCNT_W-1:0] k;
        logic [POW_TABLE_W-1:0] pw;
        k  = (r.fcnt >= FD) ? '0 : FD - r.fcnt;
        pw = pow10(4'(k));
        p.neg     = r.neg;
        p.prod    = PROD_W'(r.mag) * PROD_W'(pw[POW_W-1:0]);
        p.rnd     = r.rnd;
        p.bad     = r.bad;
        p.ovf     = r.ovf;
        p.missing = r.missing;
        return p;
    endfunction

    lane_prod_t lat_prod_reg, lon_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (f2_ready) begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f2_ready && f1_valid_reg) begin
            lat_prod_reg <= scale_lane(lat_raw_reg);
            lon_prod_reg <= scale_lane(lon_raw_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: saturate, round half up, apply sign, check limits.
    // ------------------------------------------------------------------
    function automatic logic [COORD_W+STATUS_W-1:0] finish_lane(input lane_prod_t p);
        logic [MAG_W-1:0]          m;
        logic                      ov;
        logic signed [COORD_W-1:0] v;
        ctp_status_t               st;
        ov = p.ovf;
        if (p.prod > PROD_W'(CAP)) begin
            m  = CAP;
            ov = 1'b1;
        end else begin
            m = p.prod[MAG_W-1:0];
        end
        if (p.rnd) begin
            if (m >= CAP) begin
                m  = CAP;
                ov = 1'b1;
            end else begin
                m = m + 1'b1;
            end
        end
        if (p.bad || p.missing) begin
            v  = '0;
            st = ST_MALFORMED;
        end else begin
            v  = p.neg ? (COORD_W'(0) - {1'b0, m}) : {1'b0, m};
            st = ov ? ST_RANGE : ST_OK;
        end
        return {v, st};
    endfunction

    logic [COORD_W+STATUS_W-1:0] lat_fin, lon_fin;
    logic signed [COORD_W-1:0]   lat_val, lon_val;
    ctp_status_t                 lat_st, lon_st, status_next;
    logic                        limit_fail;

    always_comb begin
        lat_fin = finish_lane(lat_prod_reg);
        lon_fin = finish_lane(lon_prod_reg);
        lat_val = lat_fin[COORD_W+STATUS_W-1:STATUS_W];
        lon_val = lon_fin[COORD_W+STATUS_W-1:STATUS_W];
        lat_st  = ctp_status_t'(lat_fin[STATUS_W-1:0]);
        lon_st  = ctp_status_t'(lon_fin[STATUS_W-1:0]);
        limit_fail = (lat_val < lat_min_reg) || (lat_val > lat_max_reg) ||
                     (lon_val < lon_min_reg) || (lon_val > lon_max_reg);
        // Malformed wins over out of range.
        if (lat_st == ST_MALFORMED || lon_st == ST_MALFORMED) begin
            status_next = ST_MALFORMED;
        end else if (lat_st == ST_RANGE || lon_st == ST_RANGE || limit_fail) begin
            status_next = ST_RANGE;
        end else begin
            status_next = ST_OK;
        end
    end

    // Output register: hold the result until the sink takes it.
    logic signed [COORD_W-1:0] lat_out_reg, lon_out_reg;
    ctp_status_t               status_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && f2_valid_reg) begin
            lat_out_reg    <= lat_val;
            lon_out_reg    <= lon_val;
            status_out_reg <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_latitude  = lat_out_reg;
    assign m_longitude = lon_out_reg;
    assign m_status    = status_out_reg;

`ifndef SYNTH
    // An end-marked beat always restarts the parser.
    a_restart_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (parse_go && in_eot_reg) |=> (phase_reg == PH_SKIP_LAT))
        else $error("parser did not restart after end of text");

    // The accumulated magnitude never passes the saturation point.
    a_mag_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.mag <= CAP)
        else $error("token magnitude above cap");

    // A result is never given the unused status code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_MALFORMED ||
                     m_status == ST_RANGE))
        else $error("unused status code on result");

    // An ok result lies inside both limit windows.
    a_ok_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |->
            (m_latitude >= lat_min_reg && m_latitude <= lat_max_reg &&
             m_longitude >= lon_min_reg && m_longitude <= lon_max_reg))
        else $error("ok status on out-of-limit coordinate");

    // A stalled stage keeps its item.
    a_f2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (f2_valid_reg && !out_free) |=> f2_valid_reg)
        else $error("scale stage dropped an item under stall");
`endif

endmodule
